[src/rsu_pkg.sv]
`timescale 1ns / 1ps
package rsu_pkg;

  localparam logic [31:0] SKIP_RESET  = 32'h0004_2000;
  localparam logic [7:0]  TOK_ZERO    = 8'h00;
  localparam logic [7:0]  TOK_FILL8   = 8'h80;
  localparam logic [7:0]  TOK_FILL16  = 8'h81;
  localparam logic [7:0]  TOK_SPACE   = 8'h82;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;
  localparam int          MARKER_LEN  = 4;

  localparam logic [7:0] MARKER [MARKER_LEN] = '{8'h73, 8'h71, 8'h73, 8'h68};

  typedef enum logic [2:0] {
    PH_SKIP    = 3'd0,
    PH_HUNT    = 3'd1,
    PH_TOKEN   = 3'd2,
    PH_COUNT8  = 3'd3,
    PH_COUNT16 = 3'd4,
    PH_VALUE   = 3'd5,
    PH_LITERAL = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  // token kind, also low/high byte select of the 16-bit count
  localparam logic [1:0] KIND_ZERO    = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_SPACE   = 2'd2;
  localparam logic [1:0] KIND_LO_BYTE = 2'd0;
  localparam logic [1:0] KIND_HI_BYTE = 2'd1;

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] count;
    logic        done;
    logic        marker;
  } res_t;

endpackage

[src/rsu_decoder.sv]
`timescale 1ns / 1ps
module rsu_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         in_acc,
  input  logic [7:0]   in_byte,
  input  logic         in_eoi,
  output logic         res_vld,
  output rsu_pkg::res_t res
);
  import rsu_pkg::*;

  logic [31:0] skip_bytes_r;
  logic [31:0] skip_left_r, skip_left_nxt;
  logic [2:0]  matched_r, matched_nxt;
  phase_t      phase_r, phase_nxt, ph;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [15:0] pend_dec;
  logic        emit;

  always_comb begin
    skip_left_nxt = skip_left_r;
    matched_nxt   = matched_r;
    kind_nxt      = kind_r;
    pend_nxt      = pend_r;
    emit          = 1'b0;
    res           = '0;
    pend_dec      = (pend_r != 16'd0) ? pend_r - 16'd1 : pend_r;
    ph            = phase_r;
    if (phase_r == PH_SKIP) begin
      if (skip_left_r != 32'd0) begin
        skip_left_nxt = skip_left_r - 32'd1;
      end else begin
        ph = PH_HUNT;
      end
    end
    phase_nxt = ph;
    unique case (ph)
      PH_SKIP: ;
      PH_HUNT: begin
        if (in_byte == MARKER[matched_r[1:0]]) begin
          matched_nxt = matched_r + 3'd1;
          if (matched_r == 3'(MARKER_LEN - 1)) begin
            emit       = 1'b1;
            res.marker = 1'b1;
            phase_nxt  = PH_TOKEN;
          end
        end else begin
          matched_nxt = 3'd0;
        end
      end
      PH_TOKEN: begin
        priority if (in_byte == TOK_ZERO) begin
          kind_nxt  = KIND_ZERO;
          phase_nxt = PH_COUNT8;
        end else if (in_byte == TOK_FILL8) begin
          kind_nxt  = KIND_FILL;
          phase_nxt = PH_COUNT8;
        end else if (in_byte == TOK_FILL16) begin
          kind_nxt  = KIND_LO_BYTE;
          phase_nxt = PH_COUNT16;
        end else if (in_byte == TOK_SPACE) begin
          kind_nxt  = KIND_SPACE;
          phase_nxt = PH_COUNT8;
        end else if (!in_byte[7]) begin
          pend_nxt  = {8'd0, in_byte};
          phase_nxt = PH_LITERAL;
        end else begin
          pend_nxt  = {9'd0, in_byte[6:0]};
          phase_nxt = PH_VALUE;
        end
      end
      PH_COUNT8: begin
        priority if (kind_r == KIND_FILL) begin
          pend_nxt  = {8'd0, in_byte};
          phase_nxt = PH_VALUE;
        end else if (kind_r == KIND_SPACE) begin
          if (in_byte != 8'd0) begin
            emit      = 1'b1;
            res.value = SPACE_CHAR;
            res.count = {8'd0, in_byte};
          end
          phase_nxt = PH_TOKEN;
        end else begin
          emit      = 1'b1;
          res.count = {8'd0, in_byte};
          if (in_byte == 8'd0) begin
            res.done  = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_TOKEN;
          end
        end
      end
      PH_COUNT16: begin
        if (kind_r == KIND_LO_BYTE) begin
          pend_nxt = {8'd0, in_byte};
          kind_nxt = KIND_HI_BYTE;
        end else begin
          pend_nxt  = pend_r | {in_byte, 8'd0};
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (pend_r != 16'd0) begin
          emit      = 1'b1;
          res.value = in_byte;
          res.count = pend_r;
        end
        pend_nxt  = 16'd0;
        phase_nxt = PH_TOKEN;
      end
      PH_LITERAL: begin
        emit      = 1'b1;
        res.value = in_byte;
        res.count = 16'd1;
        pend_nxt  = pend_dec;
        if (pend_dec == 16'd0) begin
          phase_nxt = PH_TOKEN;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
    if (in_eoi) begin
      skip_left_nxt = skip_bytes_r;
      matched_nxt   = 3'd0;
      phase_nxt     = PH_SKIP;
      kind_nxt      = KIND_ZERO;
      pend_nxt      = 16'd0;
    end
    res_vld = in_acc && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_bytes_r <= SKIP_RESET;
      skip_left_r  <= SKIP_RESET;
      matched_r    <= 3'd0;
      phase_r      <= PH_SKIP;
      kind_r       <= KIND_ZERO;
      pend_r       <= 16'd0;
    end else if (cfg_wr_en) begin
      skip_bytes_r <= cfg_wr_data;
      if (phase_r == PH_SKIP) begin
        skip_left_r <= cfg_wr_data;
      end
    end else if (in_acc) begin
      skip_left_r <= skip_left_nxt;
      matched_r   <= matched_nxt;
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      pend_r      <= pend_nxt;
    end
  end

  a_eoi_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_eoi && !cfg_wr_en |=> phase_r == PH_SKIP && matched_r == 3'd0)
    else $error("end of input did not reload");
  a_hunt_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT |-> matched_r < 3'(MARKER_LEN))
    else $error("marker match count out of range");
  a_marker_tok: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.marker && !in_eoi && !cfg_wr_en |=> phase_r == PH_TOKEN)
    else $error("marker result without token phase");

endmodule

[src/rsu_out_stage.sv]
`timescale 1ns / 1ps
module rsu_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsu_pkg::res_t push_res,
  output logic          full,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [23:0]   out_tdata,
  output logic          out_tuser,
  output logic          out_tlast
);
  import rsu_pkg::*;

  res_t       q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] sub_r;
  res_t       head;
  logic       hs, pop, sub_end;

  assign head       = q_mem_r[rd_ptr_r];
  assign full       = (cnt_r == 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign hs         = out_tvalid && out_tready;
  assign sub_end    = (sub_r == 2'(MARKER_LEN - 1));
  assign pop        = hs && (!head.marker || sub_end);

  always_comb begin
    if (head.marker) begin
      out_tdata = {16'd1, MARKER[sub_r]};
      out_tuser = 1'b0;
      out_tlast = sub_end;
    end else begin
      out_tdata = {head.count, head.value};
      out_tuser = head.done;
      out_tlast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      sub_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        sub_r    <= 2'd0;
      end else if (hs) begin
        sub_r <= sub_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_sub_marker: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r != 2'd0 |-> out_tvalid && head.marker)
    else $error("marker index set without marker word");
  a_sub_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(sub_r) && $stable(rd_ptr_r))
    else $error("stalled word changed");

endmodule

[src/rle_stream_unpacker_core.sv]
`timescale 1ns / 1ps
// channel | dir | handshake            | contents
// in_     | in  | in_tvalid/in_tready  | tdata: data_byte[7:0]; tlast: end_of_input
// out_    | out | out_tvalid/out_tready| tdata: value[7:0], repeat_res[23:8];
//         |     |                      | tuser: stream_done; tlast: group_last
// cfg_    | in  | cfg_wr_en            | skip_bytes[31:0]
//
// one input word per cycle unless full; token state updates in the cycle it is taken
// a marker match gives four output words, sent one by one from one queue entry
// results pass through a two-entry queue; in_tready drops only when it is full
// synchronous active-low reset; skip count reloads to 0x42000, no clearing pass
module rle_stream_unpacker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // value, repeat_res
  output logic        out_tuser,  // stream_done
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import rsu_pkg::*;

  logic in_acc, res_vld, full;
  res_t res;

  assign in_tready = !full;
  assign in_acc    = in_tvalid && in_tready;

  rsu_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_acc     (in_acc),
    .in_byte    (in_tdata),
    .in_eoi     (in_tlast),
    .res_vld    (res_vld),
    .res        (res)
  );

  rsu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_res  (res),
    .full      (full),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
